// ===== hdl/pfra_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the page frame allocator.
package pfra_pkg;

    localparam int FRAMES          = 16384;
    localparam int RESERVED_FRAMES = 2048;

    localparam int FRAME_W = 16;
    localparam int CNT_W   = 8;
    localparam int LANES   = 8;
    localparam int LANE_W  = $clog2(LANES);
    localparam int ROWS    = (FRAMES + LANES - 1) / LANES;
    localparam int ROW_W   = $clog2(ROWS);
    localparam int ROW_BITS = LANES * CNT_W;
    localparam int IDX_W   = FRAME_W + 1;

    localparam logic [CNT_W-1:0] RESERVED_COUNT = CNT_W'(100);
    localparam logic [CNT_W-1:0] MAX_COUNT      = CNT_W'(255);

    typedef logic [1:0] action_t;
    localparam action_t ACT_ALLOC = 2'd0;
    localparam action_t ACT_FREE  = 2'd1;
    localparam action_t ACT_SHARE = 2'd2;
    localparam action_t ACT_WFAULT = 2'd3;

    typedef logic [2:0] status_t;
    localparam status_t ST_OK      = 3'd0;
    localparam status_t ST_OOM     = 3'd1;
    localparam status_t ST_NOFRAME = 3'd2;
    localparam status_t ST_FREE    = 3'd3;
    localparam status_t ST_SAT     = 3'd4;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_FRAME,
        RES_KEEP
    } res_sel_t;

    typedef struct packed {
        logic     clr_step;
        logic     load_in;
        logic     rd_frame;
        logic     rd_scan;
        logic     wr_dec;
        logic     wr_inc;
        logic     scan_init;
        logic     scan_next;
        logic     claim;
        logic     oom;
        logic     set_res;
        status_t  res_status;
        res_sel_t res_sel;
        logic     res_copy;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        action_t action;
        logic    frame_oob;
        logic    cnt_zero;
        logic    cnt_one;
        logic    cnt_max;
        logic    row_free;
        logic    ptr_zero;
        logic    clr_last;
        logic    out_busy;
    } stat_t;

endpackage

// ===== hdl/pfra_dp.sv =====
// Datapath: reference count memory, scan pointer, free-row hint, result and output registers.
module pfra_dp (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  pfra_pkg::cmd_t                  cmd,
    output pfra_pkg::stat_t                 stat,
    input  logic [15:0]                     s_tdata,   // [15:0] frame
    input  logic [7:0]                      s_tuser,   // [1:0] action, zeros above
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [15:0]                     m_tdata,   // [15:0] result_frame
    output logic [7:0]                      m_tuser    // [2:0] status, [3] copy_needed, zeros above
);
    import pfra_pkg::*;

    logic [ROW_BITS-1:0] mem [ROWS];

    action_t             action_reg;
    logic [FRAME_W-1:0]  frame_reg;
    logic [ROW_BITS-1:0] rdata_reg;
    logic [ROW_W-1:0]    hint_reg, hint_next;
    logic [ROW_W-1:0]    ptr_reg, ptr_next;
    logic [ROW_W-1:0]    clr_ptr_reg, clr_ptr_next;
    logic [FRAME_W-1:0]  res_frame_reg;
    status_t             res_status_reg;
    logic                res_copy_reg;
    logic                m_valid_reg, m_valid_next;
    logic [15:0]         m_data_reg;
    logic [7:0]          m_user_reg;

    logic [ROW_W-1:0]    frame_row;
    logic [LANE_W-1:0]   frame_lane;
    logic [CNT_W-1:0]    cnt;
    logic                found;
    logic [LANE_W-1:0]   found_lane;
    logic [ROW_BITS-1:0] clr_row;
    logic                mem_we;
    logic [ROW_W-1:0]    mem_waddr;
    logic [ROW_BITS-1:0] mem_wdata;
    logic                mem_re;
    logic [ROW_W-1:0]    mem_raddr;

    assign frame_row  = frame_reg[ROW_W+LANE_W-1:LANE_W];
    assign frame_lane = frame_reg[LANE_W-1:0];
    assign cnt        = rdata_reg[frame_lane*CNT_W +: CNT_W];

    always_comb begin
        logic [IDX_W-1:0] idx;
        found      = 1'b0;
        found_lane = '0;
        for (int k = 0; k < LANES; k++) begin
            idx = IDX_W'({ptr_reg, LANE_W'(k)});
            if (rdata_reg[k*CNT_W +: CNT_W] == '0 && idx < IDX_W'(FRAMES)) begin
                found      = 1'b1;
                found_lane = LANE_W'(k);
            end
        end
    end

    always_comb begin
        logic [IDX_W-1:0] idx;
        for (int k = 0; k < LANES; k++) begin
            idx = IDX_W'({clr_ptr_reg, LANE_W'(k)});
            clr_row[k*CNT_W +: CNT_W] = (idx < IDX_W'(RESERVED_FRAMES)) ? RESERVED_COUNT : '0;
        end
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = frame_row;
        mem_wdata = rdata_reg;
        if (cmd.clr_step) begin
            mem_we    = 1'b1;
            mem_waddr = clr_ptr_reg;
            mem_wdata = clr_row;
        end else if (cmd.wr_dec) begin
            mem_we = 1'b1;
            mem_wdata[frame_lane*CNT_W +: CNT_W] = cnt - CNT_W'(1);
        end else if (cmd.wr_inc) begin
            mem_we = 1'b1;
            mem_wdata[frame_lane*CNT_W +: CNT_W] = cnt + CNT_W'(1);
        end else if (cmd.claim) begin
            mem_we    = 1'b1;
            mem_waddr = ptr_reg;
            mem_wdata[found_lane*CNT_W +: CNT_W] = CNT_W'(1);
        end
    end

    assign mem_re    = cmd.rd_frame | cmd.rd_scan;
    assign mem_raddr = cmd.rd_scan ? ptr_reg : frame_row;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    always_comb begin
        hint_next = hint_reg;
        if (cmd.claim) begin
            hint_next = ptr_reg;
        end else if (cmd.oom) begin
            hint_next = '0;
        end else if (cmd.wr_dec && cnt == CNT_W'(1) && frame_row > hint_reg) begin
            hint_next = frame_row;
        end
        ptr_next = ptr_reg;
        if (cmd.scan_init) begin
            ptr_next = hint_reg;
        end else if (cmd.scan_next) begin
            ptr_next = ptr_reg - ROW_W'(1);
        end
        clr_ptr_next = cmd.clr_step ? clr_ptr_reg + ROW_W'(1) : clr_ptr_reg;
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hint_reg    <= ROW_W'(ROWS - 1);
            ptr_reg     <= '0;
            clr_ptr_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            hint_reg    <= hint_next;
            ptr_reg     <= ptr_next;
            clr_ptr_reg <= clr_ptr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            action_reg <= s_tuser[1:0];
            frame_reg  <= s_tdata;
        end
        if (cmd.claim) begin
            res_frame_reg <= FRAME_W'({ptr_reg, found_lane});
        end
        if (cmd.set_res) begin
            res_status_reg <= cmd.res_status;
            res_copy_reg   <= cmd.res_copy;
            case (cmd.res_sel)
                RES_ZERO:  res_frame_reg <= '0;
                RES_FRAME: res_frame_reg <= frame_reg;
                default:   ;
            endcase
        end
        if (cmd.out_load) begin
            m_data_reg <= res_frame_reg;
            m_user_reg <= {4'b0, res_copy_reg, res_status_reg};
        end
    end

    assign stat.action    = action_reg;
    assign stat.frame_oob = {1'b0, frame_reg} >= IDX_W'(FRAMES);
    assign stat.cnt_zero  = cnt == '0;
    assign stat.cnt_one   = cnt == CNT_W'(1);
    assign stat.cnt_max   = cnt == MAX_COUNT;
    assign stat.row_free  = found;
    assign stat.ptr_zero  = ptr_reg == '0;
    assign stat.clr_last  = clr_ptr_reg == ROW_W'(ROWS - 1);
    assign stat.out_busy  = m_valid_reg & ~m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

// ===== hdl/pfra_ctrl.sv =====
// Controller: sequences clearing, count updates and the free-frame scan.
module pfra_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  pfra_pkg::stat_t stat,
    output pfra_pkg::cmd_t  cmd
);
    import pfra_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_OP_CHK,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_OLD_RD,
        S_OLD_WR,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res_sel = RES_ZERO;
        s_tready   = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE: begin
                if (stat.action == ACT_ALLOC) begin
                    cmd.scan_init = 1'b1;
                    state_next    = S_SCAN_RD;
                end else if (stat.frame_oob) begin
                    cmd.set_res    = 1'b1;
                    cmd.res_status = ST_NOFRAME;
                    state_next     = S_FINISH;
                end else begin
                    cmd.rd_frame = 1'b1;
                    state_next   = S_OP_CHK;
                end
            end
            S_OP_CHK: begin
                cmd.set_res = 1'b1;
                state_next  = S_FINISH;
                case (stat.action)
                    ACT_FREE: begin
                        if (stat.cnt_zero) begin
                            cmd.res_status = ST_FREE;
                        end else begin
                            cmd.wr_dec     = 1'b1;
                            cmd.res_status = ST_OK;
                        end
                    end
                    ACT_SHARE: begin
                        if (stat.cnt_max) begin
                            cmd.res_status = ST_SAT;
                        end else begin
                            cmd.wr_inc     = 1'b1;
                            cmd.res_status = ST_OK;
                        end
                    end
                    default: begin
                        if (stat.cnt_zero) begin
                            cmd.res_status = ST_FREE;
                        end else if (stat.cnt_one) begin
                            cmd.res_status = ST_OK;
                            cmd.res_sel    = RES_FRAME;
                        end else begin
                            cmd.set_res   = 1'b0;
                            cmd.scan_init = 1'b1;
                            state_next    = S_SCAN_RD;
                        end
                    end
                endcase
            end
            S_SCAN_RD: begin
                cmd.rd_scan = 1'b1;
                state_next  = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (stat.row_free) begin
                    cmd.claim = 1'b1;
                    if (stat.action == ACT_ALLOC) begin
                        cmd.set_res    = 1'b1;
                        cmd.res_status = ST_OK;
                        cmd.res_sel    = RES_KEEP;
                        state_next     = S_FINISH;
                    end else begin
                        state_next = S_OLD_RD;
                    end
                end else if (stat.ptr_zero) begin
                    cmd.oom        = 1'b1;
                    cmd.set_res    = 1'b1;
                    cmd.res_status = ST_OOM;
                    state_next     = S_FINISH;
                end else begin
                    cmd.scan_next = 1'b1;
                    state_next    = S_SCAN_RD;
                end
            end
            S_OLD_RD: begin
                cmd.rd_frame = 1'b1;
                state_next   = S_OLD_WR;
            end
            S_OLD_WR: begin
                cmd.wr_dec     = 1'b1;
                cmd.set_res    = 1'b1;
                cmd.res_status = ST_OK;
                cmd.res_sel    = RES_KEEP;
                cmd.res_copy   = 1'b1;
                state_next     = S_FINISH;
            end
            S_FINISH: begin
                if (!stat.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/page_frame_refcount_allocator.sv =====
// Top level of the page frame allocator with 8-bit reference counts.
//
// channel  dir  tdata                tuser
// s_       in   [15:0] frame         [1:0] action
// m_       out  [15:0] result_frame  [2:0] status, [3] copy_needed
//
// Counts are kept eight to a memory row; one row is read or written per cycle.
// Free, share, in-place write fault: decode, count check, finish; bad frame: decode, finish.
// Allocate reads and checks one row at a time, scanning from the free-row hint down (often one row).
// A copying write fault checks the count, scans like an allocate, then decrements the old frame's count.
// After reset a clearing pass writes all ROWS (2048) rows before s_tready rises.
// A result waits in the output register; the next transaction is taken meanwhile.
module page_frame_refcount_allocator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] frame
    input  logic [7:0]  s_tuser,   // [1:0] action, zeros above
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] result_frame
    output logic [7:0]  m_tuser    // [2:0] status, [3] copy_needed, zeros above
);
    import pfra_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    pfra_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pfra_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== hdl/pfra_check.sv =====
// Port-level checker for the page frame allocator, bound to the top level.
module pfra_check (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [7:0]  m_tuser
);
    import pfra_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("new transaction taken while one is in progress");

    a_err_zero_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2:0] != ST_OK |-> m_tdata == '0 && !m_tuser[3])
        else $error("error result carries a frame or copy flag");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[2:0] == ST_OK || m_tuser[2:0] == ST_OOM ||
                      m_tuser[2:0] == ST_NOFRAME || m_tuser[2:0] == ST_FREE ||
                      m_tuser[2:0] == ST_SAT) && m_tuser[7:4] == '0)
        else $error("bad status code");

endmodule

bind page_frame_refcount_allocator pfra_check u_pfra_check (.*);
